/* sv/i2crw_pkg.sv */
package i2crw_pkg;

    // Buffer depth; a power of two, so pointers and indexes wrap by masking
    localparam int BUFFER_DEPTH = 16;

    // Event codes carried by the mode field
    typedef enum logic [2:0] {
        MODE_ENABLE      = 3'd0,
        MODE_DISABLE     = 3'd1,
        MODE_START       = 3'd2,
        MODE_STOP        = 3'd3,
        MODE_TX_REQUEST  = 3'd4,
        MODE_RX_BYTE     = 3'd5,
        MODE_LOCAL_WRITE = 3'd6
    } t_mode;

    // Message phases
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_ARMED = 2'd1,
        PH_REG   = 2'd2,
        PH_DATA  = 2'd3
    } t_phase;

    // Command bytes with a fixed size; odd codes below CMD_LAST give two
    localparam logic [7:0] CMD_FIRST = 8'h00;
    localparam logic [7:0] CMD_LAST  = 8'h0F;

    localparam logic [1:0] SIZE_NONE = 2'd0;
    localparam logic [1:0] SIZE_ONE  = 2'd1;
    localparam logic [1:0] SIZE_TWO  = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic   accept;
        logic   tx;
        logic   rx_reg;
        logic   rx_data;
        logic   local_wr;
        logic   load;
        t_phase phase;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
    } t_dp_stat;

    function automatic logic [1:0] size_lookup(input logic [7:0] code);
        logic [1:0] size;
        if (code == CMD_FIRST || code == CMD_LAST) begin
            size = SIZE_ONE;
        end else if (code[7:4] == 4'h0 && code[0]) begin
            size = SIZE_TWO;
        end else begin
            size = SIZE_NONE;
        end
        return size;
    endfunction

endpackage

/* sv/i2crw_ctrl.sv */
module i2crw_ctrl
    import i2crw_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  logic [2:0] i_mode,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic {
        ST_READY,
        ST_LOAD
    } t_state;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic   r_en, n_en;
    logic   accept;
    logic   on;

    assign o_in_stall = (r_state != ST_READY);
    assign accept     = i_in_valid && (r_state == ST_READY);
    assign on         = r_en;

    always_comb begin
        n_state        = r_state;
        n_phase        = r_phase;
        n_en           = r_en;
        o_cmd          = '0;
        o_cmd.phase    = r_phase;
        unique case (r_state)
            ST_READY: begin
                if (accept) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_LOAD;
                    case (t_mode'(i_mode))
                        MODE_ENABLE: begin
                            if (r_phase == PH_IDLE) n_phase = PH_ARMED;
                            n_en = 1'b1;
                        end
                        MODE_DISABLE: n_en = 1'b0;
                        MODE_START: begin
                            if (on && r_phase == PH_ARMED) n_phase = PH_REG;
                        end
                        MODE_STOP: begin
                            if (on && r_phase == PH_REG) begin
                                n_phase = PH_DATA;
                            end else if (on && r_phase == PH_DATA) begin
                                n_phase = PH_IDLE;
                            end
                        end
                        MODE_TX_REQUEST: o_cmd.tx = on && (r_phase == PH_DATA);
                        MODE_RX_BYTE: begin
                            o_cmd.rx_reg  = on && (r_phase == PH_REG);
                            o_cmd.rx_data = on && (r_phase == PH_DATA);
                        end
                        MODE_LOCAL_WRITE: o_cmd.local_wr = 1'b1;
                        default: ;
                    endcase
                end
            end
            ST_LOAD: begin
                // hold the result until the output register frees up
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_READY;
                end
            end
            default: n_state = ST_READY;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_READY;
            r_phase <= PH_IDLE;
            r_en    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_en    <= n_en;
        end
    end

    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.tx, o_cmd.rx_reg, o_cmd.rx_data, o_cmd.local_wr}))
        else $error("more than one datapath operation at once");

    a_data_from_reg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA && $past(r_phase) != PH_DATA) |-> $past(r_phase) == PH_REG)
        else $error("data phase entered from a phase other than register");

    a_no_load_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> !o_cmd.accept)
        else $error("two events accepted back to back");

endmodule

/* sv/i2crw_dp.sv */
module i2crw_dp
    import i2crw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    output t_dp_stat   o_stat,
    input  logic [7:0] i_rx_byte,
    input  logic [3:0] i_local_index,
    input  logic [7:0] i_local_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_tx_data,
    output logic       o_tx_valid,
    output logic [1:0] o_phase,
    output logic [1:0] o_msg_len,
    output logic [3:0] o_pointer
);

    localparam int PW = $clog2(BUFFER_DEPTH);
    localparam logic [PW-1:0] LAST_IDX = PW'(BUFFER_DEPTH - 1);

    logic [7:0]          r_mem [BUFFER_DEPTH];
    logic [BUFFER_DEPTH-1:0] r_valid;
    logic [PW-1:0]       r_ptr, n_ptr;
    logic [1:0]          r_size;
    logic [7:0]          r_rd_data;
    logic                r_rd_hit;
    logic                r_pend_txv;
    logic                r_out_valid;
    logic [7:0]          r_out_tx_data;
    logic                r_out_tx_valid;
    t_phase              r_out_phase;
    logic [1:0]          r_out_size;
    logic [PW-1:0]       r_out_ptr;

    logic                wr_en;
    logic [PW-1:0]       wr_addr;
    logic [7:0]          wr_data;
    logic [PW-1:0]       ptr_inc;

    // depth is a power of two: the low bits give the index modulo the depth
    assign ptr_inc = (r_ptr == LAST_IDX) ? '0 : r_ptr + 1'b1;
    assign wr_en   = i_cmd.local_wr || i_cmd.rx_data;
    assign wr_addr = i_cmd.local_wr ? i_local_index[PW-1:0] : r_ptr;
    assign wr_data = i_cmd.local_wr ? i_local_data : i_rx_byte;

    always_comb begin
        n_ptr = r_ptr;
        if (i_cmd.rx_reg) begin
            n_ptr = i_rx_byte[PW-1:0];
        end else if (i_cmd.tx || i_cmd.rx_data) begin
            n_ptr = ptr_inc;
        end
    end

    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    // buffer storage
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        if (i_cmd.tx) r_rd_data <= r_mem[r_ptr];
    end

    // entry valid bits stand in for clearing the buffer at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (wr_en) begin
            r_valid[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr       <= '0;
            r_size      <= SIZE_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_ptr <= n_ptr;
            if (i_cmd.rx_reg) r_size <= size_lookup(i_rx_byte);
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_pend_txv <= i_cmd.tx;
        if (i_cmd.tx) r_rd_hit <= r_valid[r_ptr];
        if (i_cmd.load) begin
            r_out_tx_data  <= (r_pend_txv && r_rd_hit) ? r_rd_data : 8'd0;
            r_out_tx_valid <= r_pend_txv;
            r_out_phase    <= i_cmd.phase;
            r_out_size     <= r_size;
            r_out_ptr      <= r_ptr;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_tx_data   = r_out_tx_data;
    assign o_tx_valid  = r_out_tx_valid;
    assign o_phase     = r_out_phase;
    assign o_msg_len   = r_out_size;
    assign o_pointer   = r_out_ptr;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> (!r_out_valid || !i_out_stall))
        else $error("result loaded over a word still waiting");

    a_tx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_tx_valid) |-> o_tx_data == 8'd0)
        else $error("transmit data without a buffer read");

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= LAST_IDX)
        else $error("pointer beyond buffer depth");

endmodule

/* sv/i2c_slave_register_window.sv */
// Channel  Direction  Handshake                 Word fields
// -------  ---------  ------------------------  -------------------------------------
// in       sink       i_in_valid / o_in_stall   i_mode i_rx_byte i_local_index
//                                               i_local_data
// out      source     o_out_valid / i_out_stall o_tx_data o_tx_valid o_phase
//                                               o_msg_len o_pointer
//
// For each event, the accept edge updates the phase, pointer, size and buffer
// and launches the single buffer read; in ST_LOAD the result then moves into
// the output register once it is free. No new event is accepted until then.
// An event is accepted while the previous result still waits; its own result
// holds in the datapath for as long as i_out_stall keeps the output register full.
// Reset is synchronous and active low; it clears the buffer at once through
// one valid bit per entry, so no clearing pass follows reset.
module i2c_slave_register_window
    import i2crw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_mode,
    input  logic [7:0] i_rx_byte,
    input  logic [3:0] i_local_index,
    input  logic [7:0] i_local_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_tx_data,
    output logic       o_tx_valid,
    output logic [1:0] o_phase,
    output logic [1:0] o_msg_len,
    output logic [3:0] o_pointer
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // message phase machine and event sequencing
    i2crw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_mode     (i_mode),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // pointer, size, buffer and output register
    i2crw_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_rx_byte      (i_rx_byte),
        .i_local_index  (i_local_index),
        .i_local_data   (i_local_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_tx_data      (o_tx_data),
        .o_tx_valid     (o_tx_valid),
        .o_phase        (o_phase),
        .o_msg_len      (o_msg_len),
        .o_pointer      (o_pointer)
    );

endmodule

/* verif/i2c_slave_register_window_tb.sv */
module i2c_slave_register_window_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2crw_pkg::*;

    // Mode code that the block must ignore
    localparam logic [2:0] MODE_UNUSED = 3'd7;
    localparam int RANDOM_WORDS = 1450;
    localparam int LONG_HOLD = 250;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] rx_byte;
        logic [3:0] local_index;
        logic [7:0] local_data;
    } t_bus_event;

    typedef struct packed {
        logic [7:0] tx_data;
        logic       tx_valid;
        t_phase     phase;
        logic [1:0] msg_len;
        logic [3:0] pointer;
    } t_window_status;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [2:0] i_mode = MODE_ENABLE;
    logic [7:0] i_rx_byte = 8'h00;
    logic [3:0] i_local_index = 4'h0;
    logic [7:0] i_local_data = 8'h00;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [7:0] o_tx_data;
    logic       o_tx_valid;
    logic [1:0] o_phase;
    logic [1:0] o_msg_len;
    logic [3:0] o_pointer;

    i2c_slave_register_window uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_rx_byte      (i_rx_byte),
        .i_local_index  (i_local_index),
        .i_local_data   (i_local_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_tx_data      (o_tx_data),
        .o_tx_valid     (o_tx_valid),
        .o_phase        (o_phase),
        .o_msg_len      (o_msg_len),
        .o_pointer      (o_pointer)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the slave engine state
    t_phase     shadow_phase = PH_IDLE;
    logic       shadow_enabled = 1'b0;
    logic [3:0] shadow_pointer = 4'h0;
    logic [1:0] shadow_size = SIZE_NONE;
    logic [7:0] shadow_store [BUFFER_DEPTH] = '{default: 8'h00};

    t_bus_event     pending_words [$];
    t_window_status expected_status [$];
    t_bus_event     offered;

    int errors = 0;
    int words_queued = 0;
    int words_in = 0;
    int words_out = 0;
    int bus_reads = 0;
    int bus_stores = 0;
    int messages = 0;

    task automatic report_error(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        errors++;
    endtask

    // Size from the command byte: zero and fifteen give one, odd codes below
    // fifteen give two, everything else gives none.
    function automatic logic [1:0] command_size(input logic [7:0] cmd);
        case (cmd)
            8'h00, 8'h0F: return SIZE_ONE;
            8'h01, 8'h03, 8'h05, 8'h07, 8'h09, 8'h0B, 8'h0D: return SIZE_TWO;
            default: return SIZE_NONE;
        endcase
    endfunction

    // Apply one bus event to the shadow state and return the status word it yields
    function automatic t_window_status step_register_window(input t_bus_event ev);
        t_window_status st;
        st.tx_data  = 8'h00;
        st.tx_valid = 1'b0;
        case (ev.mode)
            MODE_ENABLE: begin
                if (shadow_phase == PH_IDLE) shadow_phase = PH_ARMED;
                shadow_enabled = 1'b1;
            end
            MODE_DISABLE: begin
                shadow_enabled = 1'b0;
            end
            MODE_START: begin
                if (shadow_enabled && shadow_phase == PH_ARMED) shadow_phase = PH_REG;
            end
            MODE_STOP: begin
                if (shadow_enabled) begin
                    if (shadow_phase == PH_REG) shadow_phase = PH_DATA;
                    else if (shadow_phase == PH_DATA) shadow_phase = PH_IDLE;
                end
            end
            MODE_TX_REQUEST: begin
                if (shadow_enabled && shadow_phase == PH_DATA) begin
                    st.tx_data  = shadow_store[shadow_pointer];
                    st.tx_valid = 1'b1;
                    shadow_pointer = shadow_pointer + 4'd1;   // wraps at the buffer end
                    bus_reads++;
                end
            end
            MODE_RX_BYTE: begin
                if (shadow_enabled && shadow_phase == PH_REG) begin
                    shadow_size    = command_size(ev.rx_byte);
                    shadow_pointer = ev.rx_byte[3:0];
                end else if (shadow_enabled && shadow_phase == PH_DATA) begin
                    shadow_store[shadow_pointer] = ev.rx_byte;
                    shadow_pointer = shadow_pointer + 4'd1;
                    bus_stores++;
                end
            end
            MODE_LOCAL_WRITE: begin
                shadow_store[ev.local_index] = ev.local_data;
            end
            default: ;
        endcase
        st.phase   = shadow_phase;
        st.msg_len = shadow_size;
        st.pointer = shadow_pointer;
        return st;
    endfunction

    task automatic queue_word(input logic [2:0] m, input logic [7:0] rx,
                              input logic [3:0] li, input logic [7:0] ld);
        t_bus_event ev;
        ev.mode        = m;
        ev.rx_byte     = rx;
        ev.local_index = li;
        ev.local_data  = ld;
        pending_words.push_back(ev);
        words_queued++;
    endtask

    // Queue an event whose unused fields carry random junk
    task automatic queue_event(input logic [2:0] m, input logic [7:0] rx);
        queue_word(m, rx, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
    endtask

    task automatic queue_local_write();
        queue_word(MODE_LOCAL_WRITE, 8'($urandom_range(0, 255)),
                   4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
    endtask

    // One well-formed message with random content; a few are broken on purpose
    task automatic queue_message();
        int n_data;
        logic [7:0] cmd;
        messages++;
        queue_event(MODE_ENABLE, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) == 0) queue_local_write();
        queue_event(MODE_START, 8'($urandom_range(0, 255)));
        // mostly the command codes near zero, sometimes any byte
        cmd = ($urandom_range(0, 9) < 6) ? 8'($urandom_range(0, 15))
                                         : 8'($urandom_range(0, 255));
        queue_event(MODE_RX_BYTE, cmd);
        if ($urandom_range(0, 9) == 0) queue_event(MODE_RX_BYTE, 8'($urandom_range(0, 255)));
        queue_event(MODE_STOP, 8'($urandom_range(0, 255)));
        // a long data phase now and then to run the pointer past the end
        n_data = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 22) : $urandom_range(1, 6);
        repeat (n_data) begin
            case ($urandom_range(0, 9))
                0: queue_local_write();
                1: begin
                    // drop events for a while, then resume
                    queue_event(MODE_DISABLE, 8'($urandom_range(0, 255)));
                    queue_event(3'($urandom_range(2, 5)), 8'($urandom_range(0, 255)));
                    queue_event(MODE_ENABLE, 8'($urandom_range(0, 255)));
                end
                2, 3, 4, 5: queue_event(MODE_TX_REQUEST, 8'($urandom_range(0, 255)));
                default: queue_event(MODE_RX_BYTE, 8'($urandom_range(0, 255)));
            endcase
        end
        if ($urandom_range(0, 9) != 0) queue_event(MODE_STOP, 8'($urandom_range(0, 255)));
    endtask

    task automatic queue_noise();
        repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 2) == 0) queue_local_write();
            else queue_event(3'($urandom_range(0, 6)), 8'($urandom_range(0, 255)));
        end
    endtask

    // Hold the stimulus until the block has returned every expected word
    task automatic wait_for_drain();
        while (pending_words.size() != 0 || i_in_valid || expected_status.size() != 0)
            @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------- stimulus
    initial begin
        // Directed: events while disabled, buffer extremes, unused mode
        queue_event(MODE_START, 8'h00);
        queue_event(MODE_RX_BYTE, 8'hFF);
        queue_event(MODE_TX_REQUEST, 8'h00);
        queue_word(MODE_LOCAL_WRITE, 8'h00, 4'hF, 8'hFF);
        queue_word(MODE_LOCAL_WRITE, 8'hFF, 4'h0, 8'hA5);
        queue_word(MODE_UNUSED, 8'hFF, 4'hF, 8'hFF);
        // Armed: transmit and receive do nothing
        queue_event(MODE_ENABLE, 8'h00);
        queue_event(MODE_TX_REQUEST, 8'h00);
        queue_event(MODE_RX_BYTE, 8'h3C);
        queue_event(MODE_STOP, 8'h00);
        // Command bytes, one beyond the buffer
        queue_event(MODE_START, 8'h00);
        queue_event(MODE_RX_BYTE, 8'hFF);
        queue_event(MODE_RX_BYTE, 8'h0F);
        queue_event(MODE_STOP, 8'h00);
        // Data phase: read across the wrap, store, then disable mid-message
        queue_event(MODE_TX_REQUEST, 8'h00);
        queue_event(MODE_TX_REQUEST, 8'h00);
        queue_event(MODE_RX_BYTE, 8'h00);
        queue_event(MODE_DISABLE, 8'h00);
        queue_event(MODE_TX_REQUEST, 8'h00);
        queue_event(MODE_STOP, 8'h00);
        queue_event(MODE_ENABLE, 8'h00);
        queue_event(MODE_RX_BYTE, 8'h80);
        queue_event(MODE_STOP, 8'h00);
        queue_event(MODE_STOP, 8'h00);
        queue_event(MODE_START, 8'h00);

        wait_for_drain();

        while (words_queued < RANDOM_WORDS / 2) begin
            if ($urandom_range(0, 6) == 0) queue_noise();
            else queue_message();
        end
        // let everything come back once before the second half
        wait_for_drain();
        while (words_queued < RANDOM_WORDS) begin
            if ($urandom_range(0, 6) == 0) queue_noise();
            else queue_message();
        end

        wait_for_drain();
        repeat (10) @(posedge i_clk);

        $display("Checked %0d status words from %0d events over %0d messages.",
                 words_out, words_in, messages);
        $display("Master read %0d bytes and stored %0d; %0d mismatches.",
                 bus_reads, bus_stores, errors);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Hold reset, then release it
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // ---------------------------------------------------------------- driver
    // Offer words in bursts of random length separated by random gaps.
    int burst_left = 8;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            // Predict on the edge that accepts the word
            if (i_in_valid && !o_in_stall) begin
                expected_status.push_back(step_register_window(offered));
                words_in++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    offered = pending_words.pop_front();
                    i_mode        <= offered.mode;
                    i_rx_byte     <= offered.rx_byte;
                    i_local_index <= offered.local_index;
                    i_local_data  <= offered.local_data;
                    i_in_valid    <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- monitor
    // Check each accepted status word and drive the stall pattern.
    t_window_status want;
    int  stall_style = 0;
    int  style_left = 0;
    int  hold_left = 0;
    logic stall_next;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_status.size() == 0) begin
                    report_error("status word arrived with nothing expected");
                end else begin
                    want = expected_status.pop_front();
                    if (o_tx_data !== want.tx_data)
                        report_error($sformatf("word %0d tx_data %0h, expected %0h",
                                               words_out, o_tx_data, want.tx_data));
                    if (o_tx_valid !== want.tx_valid)
                        report_error($sformatf("word %0d tx_valid %0b, expected %0b",
                                               words_out, o_tx_valid, want.tx_valid));
                    if (o_phase !== want.phase)
                        report_error($sformatf("word %0d phase %0d, expected %0d",
                                               words_out, o_phase, want.phase));
                    if (o_msg_len !== want.msg_len)
                        report_error($sformatf("word %0d msg_len %0d, expected %0d",
                                               words_out, o_msg_len, want.msg_len));
                    if (o_pointer !== want.pointer)
                        report_error($sformatf("word %0d pointer %0d, expected %0d",
                                               words_out, o_pointer, want.pointer));
                end
                words_out++;
                // Hold off long enough for the block to fill and stall its input
                if (words_out == 300 || words_out == 900) hold_left = LONG_HOLD;
            end

            if (style_left == 0) begin
                stall_style = $urandom_range(0, 3);
                style_left = $urandom_range(20, 80);
            end else begin
                style_left--;
            end
            case (stall_style)
                0: stall_next = 1'b0;
                1: stall_next = ($urandom_range(0, 3) == 0);
                2: stall_next = ($urandom_range(0, 3) != 0);
                default: stall_next = ~i_out_stall;
            endcase
            if (hold_left > 0) begin
                hold_left--;
                stall_next = 1'b1;
            end
            i_out_stall <= stall_next;
        end
    end

endmodule
